FILE: rtl/fcl_pkg.sv
`default_nettype none
package fcl_pkg;

	localparam int MAX_LIST_TRIANGLES = 16;
	localparam int COORD_BITS = 32;

	localparam int TRI_W = (MAX_LIST_TRIANGLES > 1) ? $clog2(MAX_LIST_TRIANGLES) : 1;
	localparam int CNT_W = $clog2(MAX_LIST_TRIANGLES + 1);
	localparam int ADDR_W = 1 + TRI_W + 2;
	localparam int MEM_DEPTH = 2 ** ADDR_W;

	localparam logic signed [31:0] COORD_HI = (COORD_BITS >= 32) ? 32'sh7fffffff :
		32'((64'd1 << (COORD_BITS - 1)) - 64'd1);
	localparam logic signed [31:0] COORD_LO = -COORD_HI - 32'sd1;

	// plane order: -x, -y, -z, +x, +y, +z
	localparam logic [2:0] PLANE_LAST = 3'd5;

	typedef logic signed [31:0] coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
		coord_t w;
	} vtx_t;

	typedef struct packed {
		vtx_t v0;
		vtx_t v1;
		vtx_t v2;
		logic culled;
	} tri_t;

	function automatic coord_t sat_coord(input coord_t v);
		coord_t r;
		r = v;
		if (v > COORD_HI) r = COORD_HI;
		if (v < COORD_LO) r = COORD_LO;
		return r;
	endfunction

	function automatic coord_t vget(input vtx_t v, input logic [1:0] i);
		coord_t r;
		unique case (i)
			2'd0: r = v.x;
			2'd1: r = v.y;
			2'd2: r = v.z;
			default: r = v.w;
		endcase
		return r;
	endfunction

	// w - s*c for the plane; negative means outside
	function automatic logic signed [33:0] measure(input vtx_t v, input logic [2:0] plane);
		logic signed [33:0] c;
		logic signed [33:0] w;
		logic signed [33:0] r;
		w = 34'(v.w);
		unique case (plane)
			3'd0, 3'd3: c = 34'(v.x);
			3'd1, 3'd4: c = 34'(v.y);
			default: c = 34'(v.z);
		endcase
		if (plane < 3'd3) r = w + c;
		else r = w - c;
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/fcl_front.sv
`default_nettype none
module fcl_front
	import fcl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire vtx_t va,
	input wire vtx_t vb,
	input wire vtx_t vc,
	output logic q_valid,
	input wire logic q_stall,
	output tri_t q_data
);

	localparam logic [1:0] F_IDLE = 2'd0;
	localparam logic [1:0] F_CULL = 2'd1;
	localparam logic [1:0] F_SEND = 2'd2;

	logic [1:0] state_q;
	tri_t tri_q;
	logic signed [67:0] acc_q, m1_q, m3_q;
	logic [32:0] d2_q, d4_q;
	logic [5:0] cnt_q;

	vtx_t sa, sb, sc;
	logic signed [32:0] d1, d2, d3, d4;
	logic signed [67:0] pp, acc_nx;

	always_comb begin
		sa = '{x: sat_coord(va.x), y: sat_coord(va.y), z: sat_coord(va.z), w: sat_coord(va.w)};
		sb = '{x: sat_coord(vb.x), y: sat_coord(vb.y), z: sat_coord(vb.z), w: sat_coord(vb.w)};
		sc = '{x: sat_coord(vc.x), y: sat_coord(vc.y), z: sat_coord(vc.z), w: sat_coord(vc.w)};
		d1 = 33'(sb.x) - 33'(sa.x);
		d2 = 33'(sc.y) - 33'(sa.y);
		d3 = 33'(sb.y) - 33'(sa.y);
		d4 = 33'(sc.x) - 33'(sa.x);
		pp = (d2_q[0] ? m1_q : 68'sd0) - (d4_q[0] ? m3_q : 68'sd0);
		// top bit of a two's complement multiplier weighs negative
		acc_nx = (cnt_q == 6'd32) ? acc_q - pp : acc_q + pp;
	end

	assign in_stall = (state_q != F_IDLE);
	assign q_valid = (state_q == F_SEND);
	assign q_data = tri_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (in_valid) state_q <= F_CULL;
				F_CULL: if (cnt_q == 6'd32) state_q <= F_SEND;
				F_SEND: if (!q_stall) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && in_valid) begin
			tri_q.v0 <= sa;
			tri_q.v1 <= sb;
			tri_q.v2 <= sc;
			tri_q.culled <= 1'b0;
			acc_q <= '0;
			m1_q <= 68'(d1);
			m3_q <= 68'(d3);
			d2_q <= d2;
			d4_q <= d4;
			cnt_q <= '0;
		end else if (state_q == F_CULL) begin
			acc_q <= acc_nx;
			m1_q <= m1_q <<< 1;
			m3_q <= m3_q <<< 1;
			d2_q <= d2_q >> 1;
			d4_q <= d4_q >> 1;
			cnt_q <= cnt_q + 6'd1;
			if (cnt_q == 6'd32) tri_q.culled <= acc_nx[67];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/fcl_queue.sv
`default_nettype none
module fcl_queue
	import fcl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic wr_valid,
	output logic wr_stall,
	input wire tri_t wr_data,
	output logic rd_valid,
	input wire logic rd_stall,
	output tri_t rd_data
);

	tri_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic push, pop;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data = mem_q[rp_q];
	assign push = wr_valid && !wr_stall;
	assign pop = rd_valid && !rd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_data;
	end

endmodule
`default_nettype wire

FILE: rtl/fcl_cut.sv
`default_nettype none
module fcl_cut
	import fcl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire vtx_t a,
	input wire vtx_t b,
	input wire logic [2:0] plane,
	output logic done,
	output vtx_t res
);

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_DIV = 2'd1;
	localparam logic [1:0] C_MUL = 2'd2;

	logic [1:0] state_q;
	logic done_q;
	vtx_t a_q, b_q, res_q;
	logic [33:0] den_q;
	logic [34:0] rem_q;
	logic [29:0] t_q;
	logic [4:0] step_q;
	logic [46:0] prod_s1, acc_q;

	logic signed [33:0] ma, mb;
	logic [32:0] mac;
	logic signed [34:0] den_full;
	logic [34:0] sh;
	logic ge;
	logic [2:0] cur_i, prv_i;
	logic signed [32:0] dl_cur, dl_prv;
	logic [32:0] mag;
	logic [16:0] op;
	logic [63:0] total;
	logic [33:0] off;
	logic [33:0] sum;
	coord_t base;

	always_comb begin
		ma = measure(a, plane);
		mb = measure(b, plane);
		mac = ma[33] ? 33'd0 : ma[32:0];
		den_full = 35'(signed'({1'b0, mac})) - 35'(mb);
		sh = {rem_q[33:0], 1'b0};
		ge = (sh >= {1'b0, den_q});
		cur_i = step_q[2:0];
		prv_i = step_q[2:0] - 3'd1;
		dl_cur = 33'(vget(b_q, cur_i[2:1])) - 33'(vget(a_q, cur_i[2:1]));
		mag = dl_cur[32] ? 33'(-dl_cur) : 33'(dl_cur);
		op = cur_i[0] ? {1'b0, mag[32:17]} : mag[16:0];
		dl_prv = 33'(vget(b_q, prv_i[2:1])) - 33'(vget(a_q, prv_i[2:1]));
		// offset rounded to nearest, ties away from zero
		total = 64'(acc_q) + {prod_s1, 17'd0} + (64'd1 << 29);
		off = total[63:30];
		base = vget(a_q, prv_i[2:1]);
		sum = dl_prv[32] ? 34'(base) - off : 34'(base) + off;
	end

	assign done = done_q;
	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == C_IDLE && start && den_full <= 35'sd0) ||
				(state_q == C_MUL && step_q == 5'd8);
			unique case (state_q)
				C_IDLE: if (start && den_full > 35'sd0) state_q <= C_DIV;
				C_DIV: if (step_q == 5'd29) state_q <= C_MUL;
				C_MUL: if (step_q == 5'd8) state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			C_IDLE: if (start) begin
				a_q <= a;
				b_q <= b;
				res_q <= a;
				den_q <= den_full[33:0];
				rem_q <= {2'b00, mac};
				t_q <= '0;
				step_q <= '0;
			end
			C_DIV: begin
				rem_q <= ge ? sh - {1'b0, den_q} : sh;
				t_q <= {t_q[28:0], ge};
				step_q <= (step_q == 5'd29) ? 5'd0 : step_q + 5'd1;
			end
			C_MUL: begin
				if (step_q != 5'd8) prod_s1 <= 47'(t_q * op);
				if (step_q != 5'd0) begin
					if (!prv_i[0]) begin
						acc_q <= prod_s1;
					end else begin
						unique case (prv_i[2:1])
							2'd0: res_q.x <= sum[31:0];
							2'd1: res_q.y <= sum[31:0];
							2'd2: res_q.z <= sum[31:0];
							default: res_q.w <= sum[31:0];
						endcase
					end
				end
				step_q <= step_q + 5'd1;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

FILE: rtl/fcl_back.sv
`default_nettype none
module fcl_back
	import fcl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic q_valid,
	output logic q_stall,
	input wire tri_t q_data,
	output logic out_valid,
	input wire logic out_stall,
	output vtx_t out_v,
	output logic [1:0] out_corner,
	output logic out_last,
	output logic out_ovf
);

	localparam logic [3:0] B_IDLE = 4'd0;
	localparam logic [3:0] B_LOAD = 4'd1;
	localparam logic [3:0] B_CLASS = 4'd2;
	localparam logic [3:0] B_CUT1 = 4'd3;
	localparam logic [3:0] B_CUT2 = 4'd4;
	localparam logic [3:0] B_PUSH = 4'd5;
	localparam logic [3:0] B_NEXT = 4'd6;
	localparam logic [3:0] B_ORD = 4'd7;
	localparam logic [3:0] B_OCAP = 4'd8;
	localparam logic [3:0] B_OHOLD = 4'd9;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LIST_TRIANGLES);

	logic [3:0] state_q;
	logic [2:0] plane_q;
	logic [CNT_W-1:0] cnt0_q, cnt1_q, j_q;
	logic [1:0] ld_q, pw_q, k_q, ni_q;
	logic which_q, run_q, ovf_q;
	vtx_t vtx_q [3];
	vtx_t ia_q, ib_q, oa_q, ob_q, d_q, e_q;

	logic [127:0] mem [MEM_DEPTH];
	logic [127:0] rdata_q;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic we;
	vtx_t wr_v;

	logic cur;
	logic [CNT_W-1:0] cnt_cur, cnt_nxt;
	logic full;
	logic signed [33:0] m0, m1, m2;
	logic o0, o1, o2;

	logic cut_start, cut_done;
	vtx_t cut_a, cut_b, cut_res;

	vtx_t out_v_q;
	logic [1:0] corner_q;
	logic last_q, ovo_q, ov_q;

	fcl_cut u_cut (
		.clk(clk),
		.arst_n(arst_n),
		.start(cut_start),
		.a(cut_a),
		.b(cut_b),
		.plane(plane_q),
		.done(cut_done),
		.res(cut_res)
	);

	always_comb begin
		cur = plane_q[0];
		cnt_cur = cur ? cnt1_q : cnt0_q;
		cnt_nxt = cur ? cnt0_q : cnt1_q;
		full = (cnt_nxt >= MAX_CNT);
		m0 = measure(vtx_q[0], plane_q);
		m1 = measure(vtx_q[1], plane_q);
		m2 = measure(vtx_q[2], plane_q);
		o0 = m0[33];
		o1 = m1[33];
		o2 = m2[33];

		cut_start = ((state_q == B_CUT1) || (state_q == B_CUT2)) && !run_q;
		if (state_q == B_CUT1) begin
			cut_a = ia_q;
			cut_b = oa_q;
		end else begin
			cut_a = (ni_q == 2'd1) ? ia_q : ib_q;
			cut_b = (ni_q == 2'd1) ? ob_q : oa_q;
		end

		unique case (ni_q)
			2'd1: begin
				unique case (pw_q)
					2'd0: wr_v = ia_q;
					2'd1: wr_v = d_q;
					default: wr_v = e_q;
				endcase
			end
			2'd2: begin
				unique case (pw_q)
					2'd0: wr_v = which_q ? ib_q : ia_q;
					2'd1: wr_v = which_q ? e_q : ib_q;
					default: wr_v = d_q;
				endcase
			end
			default: begin
				unique case (pw_q)
					2'd0: wr_v = vtx_q[0];
					2'd1: wr_v = vtx_q[1];
					default: wr_v = vtx_q[2];
				endcase
			end
		endcase

		we = (state_q == B_PUSH) && !full;
		wr_addr = {~cur, cnt_nxt[TRI_W-1:0], pw_q};
		if (state_q == B_LOAD) rd_addr = {cur, j_q[TRI_W-1:0], ld_q};
		else rd_addr = {1'b0, j_q[TRI_W-1:0], k_q};
	end

	always_ff @(posedge clk) begin
		if (we) mem[wr_addr] <= wr_v;
		rdata_q <= mem[rd_addr];
	end

	assign q_stall = (state_q != B_IDLE);
	assign out_valid = ov_q;
	assign out_v = out_v_q;
	assign out_corner = corner_q;
	assign out_last = last_q;
	assign out_ovf = ovo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			plane_q <= '0;
			cnt0_q <= '0;
			cnt1_q <= '0;
			j_q <= '0;
			ld_q <= '0;
			pw_q <= '0;
			k_q <= '0;
			ni_q <= '0;
			which_q <= 1'b0;
			run_q <= 1'b0;
			ovf_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			unique case (state_q)
				B_IDLE: if (q_valid) begin
					ovf_q <= 1'b0;
					cnt1_q <= '0;
					plane_q <= '0;
					j_q <= '0;
					if (q_data.culled) begin
						cnt0_q <= '0;
					end else begin
						cnt0_q <= CNT_W'(1);
						state_q <= B_CLASS;
					end
				end
				B_LOAD: begin
					ld_q <= ld_q + 2'd1;
					if (ld_q == 2'd3) state_q <= B_CLASS;
				end
				B_CLASS: begin
					ni_q <= 2'(3 - ({1'b0, o0} + {1'b0, o1} + {1'b0, o2}));
					pw_q <= '0;
					which_q <= 1'b0;
					priority if (o0 && o1 && o2) state_q <= B_NEXT;
					else if (!o0 && !o1 && !o2) state_q <= B_PUSH;
					else state_q <= B_CUT1;
				end
				B_CUT1, B_CUT2: begin
					if (!run_q) begin
						run_q <= 1'b1;
					end else if (cut_done) begin
						run_q <= 1'b0;
						state_q <= (state_q == B_CUT1) ? B_CUT2 : B_PUSH;
					end
				end
				B_PUSH: begin
					if (full) ovf_q <= 1'b1;
					if (full || pw_q == 2'd2) begin
						if (!full) begin
							if (cur) cnt0_q <= cnt0_q + CNT_W'(1);
							else cnt1_q <= cnt1_q + CNT_W'(1);
						end
						if (ni_q == 2'd2 && !which_q) begin
							which_q <= 1'b1;
							pw_q <= '0;
						end else begin
							state_q <= B_NEXT;
						end
					end else begin
						pw_q <= pw_q + 2'd1;
					end
				end
				B_NEXT: begin
					if (j_q < cnt_cur) begin
						ld_q <= '0;
						state_q <= B_LOAD;
					end else begin
						if (cur) cnt1_q <= '0;
						else cnt0_q <= '0;
						j_q <= '0;
						k_q <= '0;
						if (plane_q == PLANE_LAST) begin
							state_q <= (cnt0_q == '0) ? B_IDLE : B_ORD;
						end else begin
							plane_q <= plane_q + 3'd1;
						end
					end
				end
				B_ORD: state_q <= B_OCAP;
				B_OCAP: begin
					ov_q <= 1'b1;
					state_q <= B_OHOLD;
				end
				B_OHOLD: if (!out_stall) begin
					ov_q <= 1'b0;
					if (last_q) begin
						state_q <= B_IDLE;
					end else begin
						state_q <= B_ORD;
						if (k_q == 2'd2) begin
							k_q <= '0;
							j_q <= j_q + CNT_W'(1);
						end else begin
							k_q <= k_q + 2'd1;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
			// triangle finished: step to the next one in the list
			if (state_q == B_CLASS && o0 && o1 && o2) j_q <= j_q + CNT_W'(1);
			if (state_q == B_PUSH && (full || pw_q == 2'd2) && !(ni_q == 2'd2 && !which_q))
				j_q <= j_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && q_valid) begin
			vtx_q[0] <= q_data.v0;
			vtx_q[1] <= q_data.v1;
			vtx_q[2] <= q_data.v2;
		end
		if (state_q == B_LOAD && ld_q != 2'd0) begin
			unique case (ld_q)
				2'd1: vtx_q[0] <= rdata_q;
				2'd2: vtx_q[1] <= rdata_q;
				default: vtx_q[2] <= rdata_q;
			endcase
		end
		if (state_q == B_CLASS) begin
			ia_q <= !o0 ? vtx_q[0] : (!o1 ? vtx_q[1] : vtx_q[2]);
			ib_q <= !o0 ? (!o1 ? vtx_q[1] : vtx_q[2]) : vtx_q[2];
			oa_q <= o0 ? vtx_q[0] : (o1 ? vtx_q[1] : vtx_q[2]);
			ob_q <= o0 ? (o1 ? vtx_q[1] : vtx_q[2]) : vtx_q[2];
		end
		if (run_q && cut_done) begin
			if (state_q == B_CUT1) d_q <= cut_res;
			else e_q <= cut_res;
		end
		if (state_q == B_OCAP) begin
			out_v_q <= rdata_q;
			corner_q <= k_q;
			last_q <= (k_q == 2'd2) && (j_q == cnt0_q - CNT_W'(1));
			ovo_q <= ovf_q;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/frustum_triangle_clipper.sv
`default_nettype none
// Clips one clip-space triangle (three Q16.16 vertices) against the six frustum planes
// and streams the surviving triangles out vertex by vertex, corner 0..2, with
// last_vertex on the final one; a back-facing or fully clipped triangle gives no
// output. The front end (33-step winding test) takes a new triangle only when idle and
// hands it to the clipper through a two-entry queue. Per plane and per work triangle,
// the clipper fetches and classifies it (the first plane needs no fetch), cuts each
// crossing edge with a divider and then an interpolation multiply, and pushes the
// resulting triangles, with one closing step per plane; output goes one vertex at a
// time and waits on out_stall. The work lists share one single-port-read memory,
// which both the fetch and the output read through.
module frustum_triangle_clipper
	import fcl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic signed [31:0] a_x,
	input wire logic signed [31:0] a_y,
	input wire logic signed [31:0] a_z,
	input wire logic signed [31:0] a_w,
	input wire logic signed [31:0] b_x,
	input wire logic signed [31:0] b_y,
	input wire logic signed [31:0] b_z,
	input wire logic signed [31:0] b_w,
	input wire logic signed [31:0] c_x,
	input wire logic signed [31:0] c_y,
	input wire logic signed [31:0] c_z,
	input wire logic signed [31:0] c_w,
	output logic out_valid,
	input wire logic out_stall,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [31:0] out_w,
	output logic [1:0] corner,
	output logic last_vertex,
	output logic overflowed
);

	vtx_t va, vb, vc, ov;
	tri_t f_data, q_data;
	logic f_valid, f_stall, q_valid, q_stall;

	assign va = '{x: a_x, y: a_y, z: a_z, w: a_w};
	assign vb = '{x: b_x, y: b_y, z: b_z, w: b_w};
	assign vc = '{x: c_x, y: c_y, z: c_z, w: c_w};

	fcl_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.va(va),
		.vb(vb),
		.vc(vc),
		.q_valid(f_valid),
		.q_stall(f_stall),
		.q_data(f_data)
	);

	fcl_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_valid(f_valid),
		.wr_stall(f_stall),
		.wr_data(f_data),
		.rd_valid(q_valid),
		.rd_stall(q_stall),
		.rd_data(q_data)
	);

	fcl_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_stall(q_stall),
		.q_data(q_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_v(ov),
		.out_corner(corner),
		.out_last(last_vertex),
		.out_ovf(overflowed)
	);

	assign out_x = ov.x;
	assign out_y = ov.y;
	assign out_z = ov.z;
	assign out_w = ov.w;

endmodule
`default_nettype wire

FILE: verif/frustum_clip_checker.sv
`timescale 1ns / 1ps
module frustum_clip_checker
	import fcl_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic signed [31:0] a_x, a_y, a_z, a_w,
	input wire logic signed [31:0] b_x, b_y, b_z, b_w,
	input wire logic signed [31:0] c_x, c_y, c_z, c_w,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic signed [31:0] out_x, out_y, out_z, out_w,
	input wire logic [1:0] corner,
	input wire logic last_vertex,
	input wire logic overflowed,
	output int errors,
	output int pending,
	output int tris_in,
	output int verts_out,
	output int culled_seen,
	output int split_seen,
	output int ovf_seen
);

	typedef struct packed {
		vtx_t v;
		logic [1:0] corner;
		logic last;
		logic ovf;
	} clip_vertex_t;

	clip_vertex_t vertex_queue[$];
	vtx_t lists[2][MAX_LIST_TRIANGLES][3];
	int list_len[2];
	bit list_ovf;

	function automatic logic signed [33:0] plane_dist(vtx_t v, int plane);
		logic signed [33:0] c;
		case (plane % 3)
			0: c = 34'(v.x);
			1: c = 34'(v.y);
			default: c = 34'(v.z);
		endcase
		return (plane < 3) ? 34'(v.w) + c : 34'(v.w) - c;
	endfunction

	function automatic coord_t lerp_coord(coord_t a, coord_t b, logic [63:0] t);
		logic signed [33:0] delta;
		logic [63:0] mag, off;
		delta = 34'(b) - 34'(a);
		mag = delta < 0 ? 64'(-delta) : 64'(delta);
		off = (t * mag + (64'd1 << 29)) >> 30;
		return delta < 0 ? coord_t'(34'(a) - 34'(off)) : coord_t'(34'(a) + 34'(off));
	endfunction

	function automatic vtx_t edge_cut(vtx_t a, vtx_t b, int plane);
		logic signed [33:0] ma;
		logic signed [35:0] den;
		logic [63:0] t;
		vtx_t o;
		ma = plane_dist(a, plane);
		den = 36'(ma) - 36'(plane_dist(b, plane));
		if (ma < 0) ma = 0;
		if (den <= 0) return a;
		t = (64'(ma) << 30) / 64'(den);
		if (t > (64'd1 << 30)) t = 64'd1 << 30;
		o.x = lerp_coord(a.x, b.x, t);
		o.y = lerp_coord(a.y, b.y, t);
		o.z = lerp_coord(a.z, b.z, t);
		o.w = lerp_coord(a.w, b.w, t);
		return o;
	endfunction

	task automatic push_tri(int l, vtx_t p, vtx_t q, vtx_t r);
		if (list_len[l] >= MAX_LIST_TRIANGLES) begin
			list_ovf = 1;
			return;
		end
		lists[l][list_len[l]][0] = p;
		lists[l][list_len[l]][1] = q;
		lists[l][list_len[l]][2] = r;
		list_len[l]++;
	endtask

	task automatic predict_clip(vtx_t v0, vtx_t v1, vtx_t v2);
		logic signed [66:0] wind;
		vtx_t ins[3], outs[3], d, e, p;
		int ni, no, cur, nxt;
		clip_vertex_t cv;
		list_ovf = 0;
		list_len[0] = 0;
		list_len[1] = 0;
		wind = (67'(v1.x) - 67'(v0.x)) * (67'(v2.y) - 67'(v0.y))
			- (67'(v1.y) - 67'(v0.y)) * (67'(v2.x) - 67'(v0.x));
		if (wind >= 0) push_tri(0, v0, v1, v2);
		else culled_seen++;
		for (int plane = 0; plane < 6; plane++) begin
			cur = plane & 1;
			nxt = cur ^ 1;
			list_len[nxt] = 0;
			for (int j = 0; j < list_len[cur]; j++) begin
				ni = 0;
				no = 0;
				for (int k = 0; k < 3; k++) begin
					p = lists[cur][j][k];
					if (plane_dist(p, plane) < 0) outs[no++] = p;
					else ins[ni++] = p;
				end
				if (ni == 1) begin
					d = edge_cut(ins[0], outs[0], plane);
					e = edge_cut(ins[0], outs[1], plane);
					push_tri(nxt, ins[0], d, e);
				end else if (ni == 2) begin
					d = edge_cut(ins[0], outs[0], plane);
					e = edge_cut(ins[1], outs[0], plane);
					push_tri(nxt, ins[0], ins[1], d);
					push_tri(nxt, ins[1], e, d);
					split_seen++;
				end else if (ni == 3) begin
					push_tri(nxt, ins[0], ins[1], ins[2]);
				end
			end
			list_len[cur] = 0;
		end
		if (list_ovf) ovf_seen++;
		for (int j = 0; j < list_len[0]; j++)
			for (int k = 0; k < 3; k++) begin
				cv.v = lists[0][j][k];
				cv.corner = 2'(k);
				cv.last = (j == list_len[0] - 1) && (k == 2);
				cv.ovf = list_ovf;
				vertex_queue.insert(vertex_queue.size(), cv);
			end
	endtask

	always @(posedge clk or negedge arst_n) begin
		clip_vertex_t exp_v, got;
		if (!arst_n) begin
			errors <= 0;
			pending <= 0;
			tris_in <= 0;
			verts_out <= 0;
			culled_seen <= 0;
			split_seen <= 0;
			ovf_seen <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				verts_out <= verts_out + 1;
				got.v = {out_x, out_y, out_z, out_w};
				got.corner = corner;
				got.last = last_vertex;
				got.ovf = overflowed;
				if (vertex_queue.size() == 0) begin
					errors <= errors + 1;
					if (errors < 10) $display("unexpected vertex transfer %h", got);
				end else begin
					exp_v = vertex_queue.pop_front();
					if (got !== exp_v) begin
						errors <= errors + 1;
						if (errors < 10) begin
							$display("vertex mismatch: exp %h %h %h %h c%0d l%0d o%0d",
								exp_v.v.x, exp_v.v.y, exp_v.v.z, exp_v.v.w,
								exp_v.corner, exp_v.last, exp_v.ovf);
							$display("                 got %h %h %h %h c%0d l%0d o%0d",
								got.v.x, got.v.y, got.v.z, got.v.w,
								got.corner, got.last, got.ovf);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				tris_in <= tris_in + 1;
				predict_clip({a_x, a_y, a_z, a_w}, {b_x, b_y, b_z, b_w},
					{c_x, c_y, c_z, c_w});
			end
			pending <= vertex_queue.size();
		end
	end

endmodule

FILE: verif/tb_frustum_triangle_clipper.sv
`timescale 1ns / 1ps
module tb_frustum_triangle_clipper;
	import fcl_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] tri_c[12];
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] out_x, out_y, out_z, out_w;
	logic [1:0] corner;
	logic last_vertex, overflowed;
	int errors, pending, tris_in, verts_out, culled_seen, split_seen, ovf_seen;
	int send_idle_pct = 0;
	int stall_pct = 0;
	longint cycles = 0;

	initial for (int i = 0; i < 12; i++) tri_c[i] = 0;

	always #5 clk = ~clk;

	frustum_triangle_clipper u_top (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.a_x(tri_c[0]), .a_y(tri_c[1]), .a_z(tri_c[2]), .a_w(tri_c[3]),
		.b_x(tri_c[4]), .b_y(tri_c[5]), .b_z(tri_c[6]), .b_w(tri_c[7]),
		.c_x(tri_c[8]), .c_y(tri_c[9]), .c_z(tri_c[10]), .c_w(tri_c[11]),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
		.corner(corner), .last_vertex(last_vertex), .overflowed(overflowed)
	);

	frustum_clip_checker u_check (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.a_x(tri_c[0]), .a_y(tri_c[1]), .a_z(tri_c[2]), .a_w(tri_c[3]),
		.b_x(tri_c[4]), .b_y(tri_c[5]), .b_z(tri_c[6]), .b_w(tri_c[7]),
		.c_x(tri_c[8]), .c_y(tri_c[9]), .c_z(tri_c[10]), .c_w(tri_c[11]),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
		.corner(corner), .last_vertex(last_vertex), .overflowed(overflowed),
		.errors(errors), .pending(pending), .tris_in(tris_in), .verts_out(verts_out),
		.culled_seen(culled_seen), .split_seen(split_seen), .ovf_seen(ovf_seen)
	);

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
		cycles <= cycles + 1;
		if (cycles > 20000000) begin
			$display("timeout after %0d cycles, %0d vertices outstanding", cycles, pending);
			$display("[frustum_triangle_clipper] ERROR");
			$finish;
		end
	end

	// one triangle transfer with random idle cycles ahead of it; valid stays high
	// after the transfer so the caller must send again or drop it at once
	task automatic send_tri(input logic signed [31:0] v[12]);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		for (int i = 0; i < 12; i++) tri_c[i] <= v[i];
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(2 * 65536)) - 65536;
			2: return $signed($urandom_range(8 * 65536)) - 4 * 65536;
			default: return ($urandom_range(1)) ? 32'sh7fffffff : 32'sh80000000;
		endcase
	endfunction

	task automatic send_random();
		logic signed [31:0] v[12];
		int mode;
		mode = $urandom_range(9);
		for (int i = 0; i < 12; i++) begin
			if (mode == 0) v[i] = rand_coord(0);
			else if (mode == 1) v[i] = rand_coord($urandom_range(3));
			else if (mode < 5) v[i] = rand_coord(1);
			else v[i] = rand_coord(2);
			// w mostly positive so clipping is partial, not total
			if (i % 4 == 3 && mode > 1) v[i] = $urandom_range(4 * 65536, 65536);
		end
		// keep front facing for most well-formed triangles
		if (mode > 1 && $urandom_range(3) != 0 &&
			(longint'(v[4]) - v[0]) * (longint'(v[9]) - v[1]) <
			(longint'(v[5]) - v[1]) * (longint'(v[8]) - v[0]))
			for (int i = 0; i < 4; i++) begin
				logic signed [31:0] tmp;
				tmp = v[4 + i];
				v[4 + i] = v[8 + i];
				v[8 + i] = tmp;
			end
		send_tri(v);
	endtask

	task automatic set_tri(output logic signed [31:0] v[12],
		input logic signed [31:0] ax, ay, az, aw, bx, by, bz, bw, cx, cy, cz, cw);
		v = '{ax, ay, az, aw, bx, by, bz, bw, cx, cy, cz, cw};
	endtask

	localparam logic signed [31:0] ONE = 32'sh10000;
	localparam logic signed [31:0] MAXC = 32'sh7fffffff;
	localparam logic signed [31:0] MINC = 32'sh80000000;

	initial begin
		logic signed [31:0] v[12];
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// fully inside, front facing
		set_tri(v, 0, 0, 0, ONE, ONE / 2, 0, 0, ONE, 0, ONE / 2, 0, ONE); send_tri(v);
		// back facing
		set_tri(v, 0, 0, 0, ONE, 0, ONE / 2, 0, ONE, ONE / 2, 0, 0, ONE); send_tri(v);
		// degenerate (zero winding)
		set_tri(v, 0, 0, 0, ONE, 0, 0, 0, ONE, 0, 0, 0, ONE); send_tri(v);
		// one vertex inside on +x
		set_tri(v, 0, 0, 0, ONE, 3 * ONE, 0, 0, ONE, 3 * ONE, ONE / 2, 0, ONE); send_tri(v);
		// two inside on +x
		set_tri(v, 0, 0, 0, ONE, ONE / 2, -ONE / 2, 0, ONE, 3 * ONE, ONE / 2, 0, ONE);
		send_tri(v);
		// fully outside
		set_tri(v, 4 * ONE, 0, 0, ONE, 6 * ONE, 0, 0, ONE, 5 * ONE, ONE, 0, ONE); send_tri(v);
		// big triangle cut by every plane
		set_tri(v, -8 * ONE, -8 * ONE, -3 * ONE, ONE, 8 * ONE, -8 * ONE, 3 * ONE, ONE,
			0, 9 * ONE, 2 * ONE, ONE);
		send_tri(v);
		// vertex exactly on a plane
		set_tri(v, ONE, 0, 0, ONE, 2 * ONE, ONE, 0, ONE, 0, ONE, 0, ONE); send_tri(v);
		// negative w behind the eye
		set_tri(v, 0, 0, 0, -ONE, ONE, 0, 0, ONE, 0, ONE, 0, 2 * ONE); send_tri(v);
		// coordinate extremes
		set_tri(v, MINC, MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, 0, MAXC, 0, MAXC);
		send_tri(v);
		set_tri(v, MAXC, MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MINC, 0, MAXC);
		send_tri(v);
		set_tri(v, -1, -1, -1, -1, MAXC, 0, 0, MAXC, 0, MAXC, 0, MAXC); send_tri(v);
		set_tri(v, MINC, 0, 0, 0, MAXC, MINC, 0, MAXC, MINC, MAXC, MAXC, 1); send_tri(v);
		in_valid <= 0;
		@(posedge clk);

		// hold off until the block has drained
		while (pending != 0) @(posedge clk);
		repeat (400) @(posedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 7 : 45) : 0;
			stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 7 : 45) : 0;
			for (int n = 0; n < 72; n++) send_random();
		end
		in_valid <= 0;
		send_idle_pct = 0;
		stall_pct = 0;
		@(posedge clk);

		while (pending != 0) @(posedge clk);
		repeat (800) @(posedge clk);

		$display("%0d triangles in, %0d vertices out; %0d culled, %0d split, %0d overflowed",
			tris_in, verts_out, culled_seen, split_seen, ovf_seen);
		if (errors == 0)
			$display("[frustum_triangle_clipper] OK");
		else
			$display("[frustum_triangle_clipper] ERROR");
		$finish;
	end

endmodule
